[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tsm_pkg.sv]
// types and codes for the two-way sorted merge
`timescale 1ns / 1ps
`default_nettype none

package tsm_pkg;

    localparam logic [1:0] FUNC_PUSH_A = 2'd0;
    localparam logic [1:0] FUNC_PUSH_B = 2'd1;
    localparam logic [1:0] FUNC_MERGE  = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic               last;
        logic               empty_res;
        logic               dropped;
    } out_t;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

endpackage

`default_nettype wire

[sv/two_way_sorted_merge.sv]
// top level of the two-way sorted merge
`timescale 1ns / 1ps
`default_nettype none

// A push (func 0 to list A, func 1 to list B) gives no result; pushes may
// follow each other in every cycle while busy is low, and a push into a
// full list is dropped and remembered in the dropped flag. A merge
// (func 2) of N stored values holds busy high while it runs and puts out
// one result per cycle, in ascending order with ties going to list B when
// each list was pushed in ascending order; each result also passes the
// result register, and the last one carries last. The rate is one result
// per cycle, set by the single compare unit working on the registered read
// ports of the two list memories. With both lists empty a merge gives one
// result flagged empty in the next cycle and busy stays low. Each result
// is on result for exactly one cycle, marked by valid; no stall is possible.
module two_way_sorted_merge #(
    parameter int DEPTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire tsm_pkg::in_t  item,
    output logic               valid,
    output tsm_pkg::out_t      result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tsm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_a_reg, count_a_next;
    logic [CW-1:0]   count_b_reg, count_b_next;
    logic [CW-1:0]   ia_reg, ia_next;
    logic [CW-1:0]   ib_reg, ib_next;
    logic            overflow_reg, overflow_next;
    logic            valid_reg, valid_next;
    tsm_pkg::out_t   res_reg, res_next;

    logic            we_a, we_b;
    logic [31:0]     rdata_a, rdata_b;
    logic            a_has, b_has, take_a;
    logic            accept;

    tsm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (count_a_reg[AW-1:0]),
        .wdata (item.value),
        .raddr (ia_next[AW-1:0]),
        .rdata (rdata_a)
    );

    tsm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (count_b_reg[AW-1:0]),
        .wdata (item.value),
        .raddr (ib_next[AW-1:0]),
        .rdata (rdata_b)
    );

    assign a_has = ia_reg < count_a_reg;
    assign b_has = ib_reg < count_b_reg;

    tsm_cmp u_cmp (
        .a      (rdata_a),
        .b      (rdata_b),
        .a_has  (a_has),
        .b_has  (b_has),
        .take_a (take_a)
    );

    assign accept = start && !busy;
    assign busy   = (state_reg != tsm_pkg::ST_IDLE);
    assign valid  = valid_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tsm_pkg::ST_IDLE;
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            ia_reg       <= '0;
            ib_reg       <= '0;
            overflow_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_a_reg  <= count_a_next;
            count_b_reg  <= count_b_next;
            ia_reg       <= ia_next;
            ib_reg       <= ib_next;
            overflow_reg <= overflow_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        overflow_next = overflow_reg;
        valid_next    = 1'b0;
        res_next      = res_reg;
        we_a          = 1'b0;
        we_b          = 1'b0;

        unique case (state_reg)
            tsm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.func)
                        tsm_pkg::FUNC_PUSH_A:
                        begin
                            if (count_a_reg == CW'(DEPTH))
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                we_a         = 1'b1;
                                count_a_next = count_a_reg + 1'b1;
                            end
                        end
                        tsm_pkg::FUNC_PUSH_B:
                        begin
                            if (count_b_reg == CW'(DEPTH))
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                we_b         = 1'b1;
                                count_b_next = count_b_reg + 1'b1;
                            end
                        end
                        tsm_pkg::FUNC_MERGE:
                        begin
                            if (count_a_reg == '0 && count_b_reg == '0)
                            begin
                                valid_next         = 1'b1;
                                res_next.value_res = '0;
                                res_next.last      = 1'b1;
                                res_next.empty_res = 1'b1;
                                res_next.dropped   = overflow_reg;
                                overflow_next      = 1'b0;
                            end
                            else
                            begin
                                // read ports already sit at entry zero
                                state_next = tsm_pkg::ST_MERGE;
                            end
                        end
                        default:
                        begin
                            // unused selector: no effect
                        end
                    endcase
                end
            end
            tsm_pkg::ST_MERGE:
            begin
                valid_next         = 1'b1;
                res_next.empty_res = 1'b0;
                res_next.dropped   = overflow_reg;
                if (take_a)
                begin
                    res_next.value_res = rdata_a;
                    ia_next            = ia_reg + 1'b1;
                end
                else
                begin
                    res_next.value_res = rdata_b;
                    ib_next            = ib_reg + 1'b1;
                end
                res_next.last = (ia_next == count_a_reg) && (ib_next == count_b_reg);
                if (res_next.last)
                begin
                    state_next    = tsm_pkg::ST_IDLE;
                    count_a_next  = '0;
                    count_b_next  = '0;
                    ia_next       = '0;
                    ib_next       = '0;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = tsm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/tsm_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/tsm_cmp.sv]
// shared signed compare unit: head of list a strictly below head of list b
`timescale 1ns / 1ps
`default_nettype none

module tsm_cmp (
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    input  wire logic               a_has,
    input  wire logic               b_has,
    output logic                    take_a
);

    // a goes first only when b is exhausted or a is strictly less (ties go to b)
    always_comb
    begin
        take_a = a_has && (!b_has || (a < b));
    end

endmodule

`default_nettype wire

[sv/tsm_checker.sv]
// port-level checker for the two-way sorted merge, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tsm_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire tsm_pkg::in_t  item,
    input wire logic          valid,
    input wire tsm_pkg::out_t result
);

    logic merge_xfer;

    assign merge_xfer = start && !busy && (item.func == tsm_pkg::FUNC_MERGE);

    `ASSERT_SAME(a_empty_is_last, valid && result.empty_res, result.last && (result.value_res == 0), "empty result must be last with zero value")
    `ASSERT_NEXT(a_merge_reacts, merge_xfer, busy || (valid && result.empty_res), "merge transfer neither started nor gave an empty result")
    `ASSERT_SAME(a_mid_keeps_busy, valid && !result.last, busy, "merge ended before its last result")
    `ASSERT_SAME(a_last_frees, valid && result.last, !busy, "still busy after the last result")
    `ASSERT_SAME(a_no_stray_result, valid, $past(busy) || $past(merge_xfer), "result without a merge")

endmodule

bind two_way_sorted_merge tsm_checker u_tsm_checker (.*);

`default_nettype wire
